/* rtl/core/swar_pkg.sv */
// ----------------------------------------------------------------------------
// swar_pkg
// Shared types and constants of the sliding window reduction block.
// ----------------------------------------------------------------------------
package swar_pkg;

  localparam int unsigned MAX_WINDOW_DEF  = 64;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned RES_W           = 32;
  localparam int unsigned WLEN_W          = 7;
  localparam int unsigned CFG_W           = 7;
  localparam int unsigned CFG_IDX_W       = 1;

  typedef enum logic [1:0] {
    OP_SUM  = 2'd0,
    OP_PROD = 2'd1,
    OP_MAX  = 2'd2,
    OP_MIN  = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LEN = 1'd0,
    REG_OP_MODE    = 1'd1
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN
  } state_e;

  typedef struct packed {
    logic hist_shift;
    logic hist_clear;
    logic scan_load;
    logic scan_shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic load;
    logic step;
  } acc_ctrl_t;

endpackage

/* rtl/core/sliding_window_assoc_reduce.sv */
// ----------------------------------------------------------------------------
// sliding_window_assoc_reduce
// Running sum, product, maximum or minimum over the last window_len samples.
//
//   channel   dir  payload                             handshake
//   s_axis    in   tdata: sample, tuser: line_start    tvalid/tready
//   m_axis    out  tdata: window_result               tvalid/tready
//   cfg       in   cfg_idx_i, cfg_data_i               cfg_we_i
//
// an item that yields no result is taken while idle; one that yields a result
// then passes through the load and run states, set by the single accumulator
// walking the scan chain one cell per cycle.
// reset clears control, the fill count and the output valid; window_len is 3
// and the operator is maximum after reset.
// a finished result waits in the output register while the next sample is
// taken; the last fold step holds while that register is still occupied.
// ----------------------------------------------------------------------------
module sliding_window_assoc_reduce
  import swar_pkg::*;
#(
  parameter int unsigned MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [SAMPLE_BITS-1:0] sample, upper bits zero
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
  // [0] line_start
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [31:0] window_result
  output logic [RES_W-1:0]                    m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                cfg_idx_i,
  input  logic [CFG_W-1:0]                    cfg_data_i
);

  localparam int unsigned LEN_W     = $clog2(MAX_WINDOW + 1);

  state_e state_q, state_d;

  logic [WLEN_W-1:0] window_len_q;
  op_e               op_q;
  logic [LEN_W-1:0]  fill_q, fill_d;
  logic [LEN_W-1:0]  rem_q, rem_d;
  logic [LEN_W-1:0]  eff_len;
  logic [LEN_W-1:0]  fill_base;
  logic              s_xfer;
  logic              result_due;
  logic              out_free;
  logic              out_fire;
  logic              out_valid_q;
  logic [RES_W-1:0]  out_data_q;

  cell_ctrl_t cell_ctrl, cell0_ctrl;
  acc_ctrl_t  acc_ctrl;
  logic [RES_W-1:0] acc_val;

  logic [SAMPLE_BITS-1:0] sample;
  logic [SAMPLE_BITS-1:0] hist_w [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] scan_w [MAX_WINDOW];

  assign sample   = s_axis_tdata[SAMPLE_BITS-1:0];
  assign s_xfer   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_len_q <= WLEN_W'(3);
      op_q         <= OP_MAX;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_WINDOW_LEN: window_len_q <= cfg_data_i[WLEN_W-1:0];
        REG_OP_MODE:    op_q         <= op_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  // zero means one, anything past the chain length saturates
  always_comb begin
    if (window_len_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (int'(window_len_q) > int'(MAX_WINDOW)) begin
      eff_len = LEN_W'(MAX_WINDOW);
    end else begin
      eff_len = LEN_W'(window_len_q);
    end
  end

  always_comb begin
    fill_base = s_axis_tuser ? '0 : fill_q;
    fill_d    = fill_q;
    if (s_xfer) begin
      fill_d = (fill_base < LEN_W'(MAX_WINDOW)) ? fill_base + LEN_W'(1) : fill_base;
    end
  end

  assign result_due = fill_d >= eff_len;
  assign out_fire   = (state_q == ST_RUN) && (rem_q == '0) && out_free;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (s_xfer && result_due) state_d = ST_LOAD;
      ST_LOAD: state_d = ST_RUN;
      ST_RUN:  if (out_fire) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready        = (state_q == ST_IDLE);
    cell_ctrl.hist_shift = s_xfer;
    cell_ctrl.hist_clear = s_xfer && s_axis_tuser;
    cell_ctrl.scan_load  = (state_q == ST_LOAD);
    cell_ctrl.scan_shift = (state_q == ST_RUN) && (rem_q != '0);
    acc_ctrl.load        = (state_q == ST_LOAD);
    acc_ctrl.step        = (state_q == ST_RUN) && (rem_q != '0);
    cell0_ctrl            = cell_ctrl;
    cell0_ctrl.hist_clear = 1'b0;
  end

  always_comb begin
    rem_d = rem_q;
    if (s_xfer) begin
      rem_d = eff_len - LEN_W'(1);
    end else if (acc_ctrl.step) begin
      rem_d = rem_q - LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      rem_q   <= rem_d;
      if (out_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      out_data_q <= acc_val;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // history chain, newest sample in cell 0
  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    logic [SAMPLE_BITS-1:0] hist_in, hist_load, scan_in;
    cell_ctrl_t             ctrl;

    if (i == 0) begin : g_head
      assign hist_in = sample;
      assign ctrl    = cell0_ctrl;
    end else begin : g_body
      assign hist_in = hist_w[i-1];
      assign ctrl    = cell_ctrl;
    end

    if (i == MAX_WINDOW - 1) begin : g_tail
      assign hist_load = '0;
      assign scan_in   = '0;
    end else begin : g_link
      assign hist_load = hist_w[i+1];
      assign scan_in   = scan_w[i+1];
    end

    swar_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .hist_i     (hist_in),
      .hist_load_i(hist_load),
      .scan_i     (scan_in),
      .hist_o     (hist_w[i]),
      .scan_o     (scan_w[i])
    );
  end

  swar_acc #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_acc (
    .clk_i (clk_i),
    .ctrl_i(acc_ctrl),
    .op_i  (op_q),
    .init_i(hist_w[0]),
    .head_i(scan_w[0]),
    .acc_o (acc_val)
  );

endmodule

/* rtl/core/swar_cell.sv */
// ----------------------------------------------------------------------------
// swar_cell
// One history slot: a history register shifting toward older samples and a
// scan register shifting toward the accumulator.
// ----------------------------------------------------------------------------
module swar_cell
  import swar_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  cell_ctrl_t             ctrl_i,
  input  logic [SAMPLE_BITS-1:0] hist_i,
  input  logic [SAMPLE_BITS-1:0] hist_load_i,
  input  logic [SAMPLE_BITS-1:0] scan_i,
  output logic [SAMPLE_BITS-1:0] hist_o,
  output logic [SAMPLE_BITS-1:0] scan_o
);

  logic [SAMPLE_BITS-1:0] hist_q, hist_d;
  logic [SAMPLE_BITS-1:0] scan_q, scan_d;

  always_comb begin
    hist_d = hist_q;
    if (ctrl_i.hist_shift) begin
      hist_d = ctrl_i.hist_clear ? '0 : hist_i;
    end
  end

  always_comb begin
    scan_d = scan_q;
    if (ctrl_i.scan_load) begin
      scan_d = hist_load_i;
    end else if (ctrl_i.scan_shift) begin
      scan_d = scan_i;
    end
  end

  always_ff @(posedge clk_i) begin
    hist_q <= hist_d;
    scan_q <= scan_d;
  end

  assign hist_o = hist_q;
  assign scan_o = scan_q;

endmodule

/* rtl/core/swar_acc.sv */
// ----------------------------------------------------------------------------
// swar_acc
// Accumulator folding one sample per cycle with the selected operator.
// ----------------------------------------------------------------------------
module swar_acc
  import swar_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  acc_ctrl_t              ctrl_i,
  input  op_e                    op_i,
  input  logic [SAMPLE_BITS-1:0] init_i,
  input  logic [SAMPLE_BITS-1:0] head_i,
  output logic [RES_W-1:0]       acc_o
);

  logic        [RES_W-1:0] acc_q, acc_d;
  logic signed [RES_W-1:0] init_ext, head_ext, acc_s;
  logic        [RES_W-1:0] comb_res;

  assign init_ext = RES_W'($signed(init_i));
  assign head_ext = RES_W'($signed(head_i));
  assign acc_s    = $signed(acc_q);

  always_comb begin
    case (op_i)
      OP_SUM:  comb_res = acc_q + head_ext;
      OP_PROD: comb_res = acc_q * head_ext;
      OP_MAX:  comb_res = (acc_s < head_ext) ? head_ext : acc_q;
      OP_MIN:  comb_res = (head_ext < acc_s) ? head_ext : acc_q;
      default: comb_res = acc_q;
    endcase
  end

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.load) begin
      acc_d = init_ext;
    end else if (ctrl_i.step) begin
      acc_d = comb_res;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

/* rtl/core/swar_checker.sv */
// ----------------------------------------------------------------------------
// swar_checker
// Port-level checks of the sliding window reduction block.
// ----------------------------------------------------------------------------
module swar_checker
  import swar_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [RES_W-1:0] m_axis_tdata
);

  logic s_xfer;
  assign s_xfer = s_axis_tvalid && s_axis_tready;

  // a stalled result stays offered
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a new result only appears at the end of a fold, when input is closed
  a_rise_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared while input was open");

  // the fold passes through the load and run states before a result rises
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer |=> !$rose(m_axis_tvalid))
    else $error("result too soon after input transfer");

endmodule

bind sliding_window_assoc_reduce swar_checker u_swar_checker (.*);
